// ===== design/tpmt_pkg.sv =====
`default_nettype none
package tpmt_pkg;
	localparam int unsigned CAPACITY    = 1024;
	localparam int unsigned COORD_WIDTH = 16;
	localparam int unsigned IDX_W       = $clog2(CAPACITY);
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam int unsigned TOL_W       = 15;
	localparam int unsigned MAG_W       = 2 * COORD_WIDTH + 2;
	localparam int unsigned SUM_W       = COORD_WIDTH + 2;
	localparam int unsigned SLK_W       = SUM_W + TOL_W + 1;
	localparam int unsigned OUT_IDX_W   = 10;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;
endpackage
`default_nettype wire

// ===== design/tpmt_divider.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module tpmt_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [tpmt_pkg::MAG_W-1:0]    dividend,
	input  wire logic [tpmt_pkg::TOL_W-1:0]    divisor,
	output logic                               done,
	output logic [tpmt_pkg::MAG_W-1:0]         quotient
);
	localparam int unsigned STEP_W = $clog2(tpmt_pkg::MAG_W + 1);

	logic [STEP_W-1:0]            step_q;
	logic                         busy_q;
	logic [tpmt_pkg::TOL_W:0]     rem_q;
	logic [tpmt_pkg::MAG_W-1:0]   quo_q;
	logic [tpmt_pkg::TOL_W-1:0]   div_q;
	logic [tpmt_pkg::TOL_W:0]     shifted;
	logic                         ge;

	// shift in next dividend bit and trial subtract
	assign shifted = {rem_q[tpmt_pkg::TOL_W-1:0], quo_q[tpmt_pkg::MAG_W-1]};
	assign ge      = shifted >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(tpmt_pkg::MAG_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= (divisor == '0) ? tpmt_pkg::TOL_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= ge ? shifted - {1'b0, div_q} : shifted;
			quo_q <= {quo_q[tpmt_pkg::MAG_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== design/tolerance_point_merge_table.sv =====
`default_nettype none
// Point merge table: welds incoming 3-D points onto stored points within merge_tol.
// Input channel s_axis: one word per point, tdata = {z, y, x}, 16-bit signed each.
// Output channel m_axis: one word per point, tdata = point_index (10 bits, zero
// padded to 16); tuser = {table_full, merged}.
// Config channel cfg: writes merge_tol (15 bits); write only while idle.
// Each point computes magnitude, then slack, then scans every stored entry
// through the three stores, one entry per cycle with a registered read and a
// two-stage compare pipeline. On a miss with room in the table the bucket
// floor(m/tol) comes from a serial divider, then the entry is written. The
// table holds up to 1024 stored points. One point at a time.
// The result sits in an output register; while the receiver stalls it holds and
// no new point is taken. Reset clears the count and tol=1; stores are not cleared.
module tolerance_point_merge_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // coord_x, coord_y, coord_z
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // point_index, zero fill
	output logic [1:0]       m_axis_tuser,   // merged, table_full
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data        // merge_tol
);
	localparam int unsigned IW = tpmt_pkg::IDX_W;
	localparam int unsigned CW = tpmt_pkg::CNT_W;
	localparam int unsigned MW = tpmt_pkg::MAG_W;
	localparam int unsigned SW = tpmt_pkg::SLK_W;
	localparam int unsigned DW = tpmt_pkg::COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * tpmt_pkg::COORD_WIDTH;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_SLACK, ST_SCAN, ST_DIV, ST_WRITE, ST_OUT}
		state_t;

	state_t                       state_q;
	logic [tpmt_pkg::TOL_W-1:0]   tol_q;
	logic [CW-1:0]                count_q;
	tpmt_pkg::point_t             pt_q;
	logic [MW-1:0]                mag_q;
	logic [tpmt_pkg::SUM_W-1:0]   absum_q;
	logic [SW-1:0]                slack_q;
	logic [2*tpmt_pkg::TOL_W-1:0] tolsq_q;
	logic [CW-1:0]                rd_idx_q;
	logic [IW-1:0]                best_q;
	logic [MW-1:0]                best_bkt_q;
	logic                         found_q;
	logic [tpmt_pkg::OUT_IDX_W-1:0] out_idx_q;
	logic                         out_merged_q;
	logic                         out_full_q;

	// stores
	tpmt_pkg::point_t point_mem [tpmt_pkg::CAPACITY];
	logic [MW-1:0]    mag_mem   [tpmt_pkg::CAPACITY];
	logic [MW-1:0]    bkt_mem   [tpmt_pkg::CAPACITY];
	tpmt_pkg::point_t rd_pt;
	logic [MW-1:0]    rd_mag;
	logic [MW-1:0]    rd_bkt;
	logic             mem_we;

	// pipeline
	logic             v_s1, v_s2;
	logic [IW-1:0]    idx_s1, idx_s2;
	logic [2*DW-1:0]  dx2_s2, dy2_s2, dz2_s2;
	logic             near_s2;
	logic [MW-1:0]    bkt_s2;

	tpmt_pkg::coord_t in_x, in_y, in_z;
	logic [DW-2:0]    ax, ay, az;
	logic signed [DW-1:0] dx, dy, dz;
	logic [DW-2:0]    adx, ady, adz;
	logic [MW-1:0]    mdiff;
	logic [MW:0]      d2_sum;
	logic             hit_s2;
	logic             div_start, div_done;
	logic [MW-1:0]    div_quo;

	assign in_x = s_axis_tdata[15:0];
	assign in_y = s_axis_tdata[31:16];
	assign in_z = s_axis_tdata[47:32];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {6'b0, out_idx_q};
	assign m_axis_tuser  = {out_full_q, out_merged_q};

	// absolute values of the held point
	assign ax = pt_q.x[DW-2] ? (DW-1)'(-pt_q.x) : (DW-1)'(pt_q.x);
	assign ay = pt_q.y[DW-2] ? (DW-1)'(-pt_q.y) : (DW-1)'(pt_q.y);
	assign az = pt_q.z[DW-2] ? (DW-1)'(-pt_q.z) : (DW-1)'(pt_q.z);

	// stage 1 compare on read data
	assign dx    = DW'(pt_q.x) - DW'(rd_pt.x);
	assign dy    = DW'(pt_q.y) - DW'(rd_pt.y);
	assign dz    = DW'(pt_q.z) - DW'(rd_pt.z);
	assign adx   = dx[DW-1] ? (DW-1)'(-dx) : (DW-1)'(dx);
	assign ady   = dy[DW-1] ? (DW-1)'(-dy) : (DW-1)'(dy);
	assign adz   = dz[DW-1] ? (DW-1)'(-dz) : (DW-1)'(dz);
	assign mdiff = (rd_mag > mag_q) ? rd_mag - mag_q : mag_q - rd_mag;

	assign d2_sum = (MW+1)'(dx2_s2) + (MW+1)'(dy2_s2) + (MW+1)'(dz2_s2);
	assign hit_s2 = v_s2 && near_s2 && (d2_sum <= (MW+1)'(tolsq_q));

	assign mem_we    = (state_q == ST_WRITE);
	assign div_start = (state_q == ST_SCAN) && !v_s1 && !v_s2 && rd_idx_q == count_q
		&& !found_q && !hit_s2 && count_q != CW'(tpmt_pkg::CAPACITY);

	tpmt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (tol_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// memory read and append write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			point_mem[count_q[IW-1:0]] <= pt_q;
			mag_mem[count_q[IW-1:0]]   <= mag_q;
			bkt_mem[count_q[IW-1:0]]   <= div_quo;
		end
		rd_pt  <= point_mem[rd_idx_q[IW-1:0]];
		rd_mag <= mag_mem[rd_idx_q[IW-1:0]];
		rd_bkt <= bkt_mem[rd_idx_q[IW-1:0]];
	end

	// compare pipeline data
	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q[IW-1:0];
		idx_s2  <= idx_s1;
		dx2_s2  <= (2*DW)'(PW'(adx) * PW'(adx));
		dy2_s2  <= (2*DW)'(PW'(ady) * PW'(ady));
		dz2_s2  <= (2*DW)'(PW'(adz) * PW'(adz));
		near_s2 <= (mdiff <= slack_q);
		bkt_s2  <= rd_bkt;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tol_q        <= tpmt_pkg::TOL_W'(1);
			count_q      <= '0;
			pt_q         <= '0;
			mag_q        <= '0;
			absum_q      <= '0;
			slack_q      <= '0;
			tolsq_q      <= '0;
			rd_idx_q     <= '0;
			best_q       <= '0;
			best_bkt_q   <= '0;
			found_q      <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_idx_q    <= '0;
			out_merged_q <= 1'b0;
			out_full_q   <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid)
						tol_q <= cfg_data;
					if (s_axis_tvalid) begin
						pt_q    <= '{in_x, in_y, in_z};
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					mag_q   <= MW'(PW'(ax) * PW'(ax)) + MW'(PW'(ay) * PW'(ay))
						+ MW'(PW'(az) * PW'(az));
					absum_q <= tpmt_pkg::SUM_W'(ax) + tpmt_pkg::SUM_W'(ay)
						+ tpmt_pkg::SUM_W'(az);
					tolsq_q <= tol_q * tol_q;
					state_q <= ST_SLACK;
				end
				ST_SLACK: begin
					slack_q  <= {(SW-1)'(absum_q) * (SW-1)'(tol_q), 1'b0};
					rd_idx_q <= '0;
					found_q  <= 1'b0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_idx_q != count_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						v_s1     <= 1'b1;
					end
					if (hit_s2 && (!found_q || bkt_s2 < best_bkt_q)) begin
						found_q    <= 1'b1;
						best_q     <= idx_s2;
						best_bkt_q <= bkt_s2;
					end
					if (rd_idx_q == count_q && !v_s1 && !v_s2) begin
						if (found_q) begin
							out_idx_q    <= tpmt_pkg::OUT_IDX_W'(best_q);
							out_merged_q <= 1'b1;
							out_full_q   <= 1'b0;
							state_q      <= ST_OUT;
						end else if (count_q == CW'(tpmt_pkg::CAPACITY)) begin
							out_idx_q    <= '0;
							out_merged_q <= 1'b0;
							out_full_q   <= 1'b1;
							state_q      <= ST_OUT;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					out_idx_q    <= tpmt_pkg::OUT_IDX_W'(count_q);
					out_merged_q <= 1'b0;
					out_full_q   <= 1'b0;
					count_q      <= count_q + 1'b1;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(tpmt_pkg::CAPACITY)) else $error("count overflow");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_merged_q && out_full_q)) else $error("merged and full together");
	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> count_q == $past(count_q) + 1'b1) else $error("count not advanced");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= count_q) else $error("scan past count");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
	typedef struct {
		int unsigned idx;
		bit          merged;
		bit          full;
	} weld_res_t;

	typedef struct {
		int  x, y, z;
		bit  known;
		int  idx;
		bit  merged;
		bit  full;
	} vec_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [14:0] cfg_data = '0;

	tolerance_point_merge_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the table
	int                stored_x [tpmt_pkg::CAPACITY];
	int                stored_y [tpmt_pkg::CAPACITY];
	int                stored_z [tpmt_pkg::CAPACITY];
	longint unsigned   stored_mag [tpmt_pkg::CAPACITY];
	longint unsigned   stored_bucket [tpmt_pkg::CAPACITY];
	int unsigned       stored_count = 0;
	longint unsigned   cur_tol = 1;

	weld_res_t pending_welds[$];
	int        n_errors = 0;
	int        n_words = 0;
	int        n_merged = 0;
	int        n_appended = 0;
	int        n_full = 0;
	bit        no_gaps = 1'b0;

	function automatic longint unsigned mag_abs(int v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// welds one point into the shadow table and returns the expected word
	function automatic weld_res_t weld_point(int x, int y, int z);
		weld_res_t       r;
		longint unsigned m, absum, slack, tol_sq, diff, d2, dv;
		bit              hit;
		int unsigned     best;
		m = mag_abs(x) * mag_abs(x) + mag_abs(y) * mag_abs(y) + mag_abs(z) * mag_abs(z);
		absum = mag_abs(x) + mag_abs(y) + mag_abs(z);
		slack = 2 * cur_tol * absum;
		tol_sq = cur_tol * cur_tol;
		hit = 1'b0;
		best = 0;
		for (int unsigned i = 0; i < stored_count; i++) begin
			diff = (stored_mag[i] > m) ? stored_mag[i] - m : m - stored_mag[i];
			if (diff > slack)
				continue;
			dv = mag_abs(x - stored_x[i]);
			d2 = dv * dv;
			dv = mag_abs(y - stored_y[i]);
			d2 += dv * dv;
			dv = mag_abs(z - stored_z[i]);
			d2 += dv * dv;
			if (d2 > tol_sq)
				continue;
			if (!hit || stored_bucket[i] < stored_bucket[best]) begin
				best = i;
				hit = 1'b1;
			end
		end
		if (hit) begin
			r.idx = best % 1024;
			r.merged = 1'b1;
			r.full = 1'b0;
		end else if (stored_count >= tpmt_pkg::CAPACITY) begin
			r.idx = 0;
			r.merged = 1'b0;
			r.full = 1'b1;
		end else begin
			stored_x[stored_count] = x;
			stored_y[stored_count] = y;
			stored_z[stored_count] = z;
			stored_mag[stored_count] = m;
			stored_bucket[stored_count] = m / ((cur_tol == 0) ? 1 : cur_tol);
			r.idx = stored_count % 1024;
			r.merged = 1'b0;
			r.full = 1'b0;
			stored_count++;
		end
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// result receiver stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			stall_left <= gap_len();
			m_axis_tready <= 1'b1;
		end
	end

	// compare each result word against the oldest expectation
	always @(posedge clk) begin
		weld_res_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_words++;
			if (pending_welds.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result word: index %0d tuser %b",
						m_axis_tdata[9:0], m_axis_tuser);
			end else begin
				w = pending_welds.pop_front();
				if (m_axis_tdata[9:0] != w.idx[9:0] || m_axis_tuser[0] != w.merged ||
						m_axis_tuser[1] != w.full || m_axis_tdata[15:10] != '0) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch: exp index %0d merged %0d full %0d, ",
							"got tdata %h tuser %b"},
							w.idx, w.merged, w.full, m_axis_tdata, m_axis_tuser);
				end
				if (w.full)
					n_full++;
				else if (w.merged)
					n_merged++;
				else
					n_appended++;
			end
		end
	end

	// present one point and hold it until taken
	task automatic send_point(int x, int y, int z, bit known, weld_res_t typed);
		weld_res_t w;
		int        g;
		s_axis_tdata <= {16'(z), 16'(y), 16'(x)};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		w = weld_point(x, y, z);
		pending_welds.insert(pending_welds.size(), known ? typed : w);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_welds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_tol(int unsigned v);
		drain_results();
		cfg_data <= 15'(v);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cur_tol = v & 16'h7fff;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly points near stored ones, some duplicates, some anywhere
	task automatic random_points(int n_pts);
		int        x, y, z, k, r, span;
		weld_res_t none;
		none = '{0, 0, 0};
		for (int i = 0; i < n_pts; i++) begin
			r = $urandom_range(0, 99);
			span = (cur_tol > 3000) ? 3000 : int'(cur_tol) + 2;
			if (stored_count == 0 || r < 15) begin
				x = $signed(16'($urandom));
				y = $signed(16'($urandom));
				z = $signed(16'($urandom));
			end else begin
				k = $urandom_range(0, stored_count - 1);
				x = stored_x[k];
				y = stored_y[k];
				z = stored_z[k];
				if (r >= 30) begin
					x = clamp16(x + $urandom_range(0, 2 * span) - span);
					y = clamp16(y + $urandom_range(0, 2 * span) - span);
					z = clamp16(z + $urandom_range(0, 2 * span) - span);
				end
			end
			if (i % 60 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_point(x, y, z, 1'b0, none);
		end
		no_gaps = 1'b0;
	endtask

	vec_row_t vec_rows[16] = '{
		'{0, 0, 0, 1, 0, 0, 0},
		'{0, 0, 0, 1, 0, 1, 0},
		'{32767, 32767, 32767, 1, 1, 0, 0},
		'{-32768, -32768, -32768, 1, 2, 0, 0},
		'{1, 0, 0, 1, 0, 1, 0},
		'{-32768, -32768, -32768, 1, 2, 1, 0},
		'{32767, -32768, 0, 0, 0, 0, 0},
		'{-32768, 32767, -32768, 0, 0, 0, 0},
		'{-1, -1, -1, 0, 0, 0, 0},
		'{2, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0},
		'{0, 1, 1, 0, 0, 0, 0},
		'{21845, -21846, 10922, 0, 0, 0, 0},
		'{-21846, 21845, -10923, 0, 0, 0, 0},
		'{32766, 32767, 32767, 0, 0, 0, 0},
		'{0, 0, -1, 0, 0, 0, 0}
	};

	initial begin
		weld_res_t typed;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points at the reset tolerance
		foreach (vec_rows[i]) begin
			typed = '{vec_rows[i].idx, vec_rows[i].merged, vec_rows[i].full};
			send_point(vec_rows[i].x, vec_rows[i].y, vec_rows[i].z, vec_rows[i].known, typed);
		end

		// random phases over several tolerances
		write_tol(5);
		random_points(150);
		write_tol(32767);
		random_points(80);
		write_tol(300);
		random_points(180);
		write_tol(1);
		random_points(120);

		// tolerance zero: only exact duplicates merge
		write_tol(0);
		random_points(20);
		drain_results();
		repeat (60) @(posedge clk);

		$display("%0d result words: %0d merged, %0d appended, %0d dropped on a full table",
			n_words, n_merged, n_appended, n_full);
		$display("tolerances 0, 1, 5, 300 and 32767 used; %0d mismatches", n_errors);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
